/* src/usptf_pkg.sv */
// ----------------------------------------------------------------------------
// usptf_pkg
// Shared types, constants and the character filter for the paced text queue.
// ----------------------------------------------------------------------------
package usptf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4096;

  localparam logic [7:0] CHAR_INTERVAL_RST = 8'd2;
  localparam logic [7:0] PACE_SATURATED    = 8'hFF;

  // Request kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // UTF-8 lead byte masks and codes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] PRINTABLE_LOW  = 8'h20;
  localparam logic [7:0] PRINTABLE_HIGH = 8'h7E;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last_of_write;
  } in_item_t;

  typedef struct packed {
    logic        char_valid;
    logic [6:0]  char_out;
    logic [11:0] queue_level;
    logic        dropped;
  } out_item_t;

  // Result information known when the request is taken; the character
  // itself follows in the next cycle from the store's registered read.
  typedef struct packed {
    logic        char_valid;
    logic [11:0] queue_level;
    logic        dropped;
  } res_info_t;

  function automatic logic keeps_char(input logic [7:0] c);
    keeps_char = (c == CHAR_LF) || (c == CHAR_TAB) ||
                 ((c >= PRINTABLE_LOW) && (c <= PRINTABLE_HIGH));
  endfunction

endpackage

/* src/usptf_char_ram.sv */
// ----------------------------------------------------------------------------
// usptf_char_ram
// Character store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module usptf_char_ram #(
  parameter int unsigned DEPTH = usptf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [6:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [6:0]        rdata_r
);
  import usptf_pkg::*;

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* src/usptf_ctrl.sv */
// ----------------------------------------------------------------------------
// usptf_ctrl
// Byte filter, queue pointers and pace counter; drives the store accesses.
// ----------------------------------------------------------------------------
module usptf_ctrl #(
  parameter int unsigned DEPTH = usptf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PTR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  usptf_pkg::in_item_t in_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output logic                mem_we,
  output logic [PTR_W-1:0]    mem_waddr,
  output logic [6:0]          mem_wdata,
  output logic                mem_re,
  output logic [PTR_W-1:0]    mem_raddr,
  output usptf_pkg::res_info_t info
);
  import usptf_pkg::*;

  localparam int unsigned LVL_W = PTR_W + 1;

  logic [PTR_W-1:0] rp_r, rp_nxt, wp_r, wp_nxt, rp_inc, wp_inc;
  logic [1:0]       skip_r, skip_nxt;
  logic             drop_r, drop_nxt;
  logic [7:0]       pace_r, pace_nxt, pace_inc;
  logic [7:0]       interval_r;
  logic [LVL_W-1:0] level;
  logic [7:0]       c;

  assign c         = in_item.data_byte;
  assign rp_inc    = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wp_inc    = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign pace_inc  = (pace_r == PACE_SATURATED) ? pace_r : pace_r + 8'd1;
  assign mem_waddr = wp_r;
  assign mem_raddr = rp_r;
  assign mem_wdata = c[6:0];

  always_comb begin
    rp_nxt          = rp_r;
    wp_nxt          = wp_r;
    skip_nxt        = skip_r;
    drop_nxt        = drop_r;
    pace_nxt        = pace_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    info.char_valid = 1'b0;
    info.dropped    = 1'b0;
    if (in_fire) begin
      if (in_item.kind == KIND_BYTE) begin
        if (skip_r != 2'd0) begin
          skip_nxt = skip_r - 2'd1;
        end else if (c[7]) begin
          if ((c & LEAD2_MASK) == LEAD2_CODE) begin
            skip_nxt = 2'd1;
          end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            skip_nxt = 2'd2;
          end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
            skip_nxt = 2'd3;
          end
        end else if (keeps_char(c)) begin
          // Once a write has hit a full queue, the rest of it is lost.
          if (drop_r || (wp_inc == rp_r)) begin
            drop_nxt     = 1'b1;
            info.dropped = 1'b1;
          end else begin
            mem_we = 1'b1;
            wp_nxt = wp_inc;
          end
        end
        if (in_item.last_of_write) begin
          skip_nxt = 2'd0;
          drop_nxt = 1'b0;
        end
      end else begin
        pace_nxt = pace_inc;
        if ((rp_r != wp_r) && (pace_inc >= interval_r)) begin
          info.char_valid = 1'b1;
          mem_re          = 1'b1;
          rp_nxt          = rp_inc;
          pace_nxt        = 8'd0;
        end
      end
    end
    if (wp_nxt >= rp_nxt) begin
      level = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      level = {1'b0, wp_nxt} + LVL_W'(DEPTH) - {1'b0, rp_nxt};
    end
    info.queue_level = 12'(level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      wp_r       <= '0;
      skip_r     <= 2'd0;
      drop_r     <= 1'b0;
      pace_r     <= PACE_SATURATED;
      interval_r <= CHAR_INTERVAL_RST;
    end else begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      skip_r <= skip_nxt;
      drop_r <= drop_nxt;
      pace_r <= pace_nxt;
      if (cfg_we) begin
        interval_r <= cfg_data;
      end
    end
  end

endmodule

/* src/utf8_strip_paced_text_fifo.sv */
// ----------------------------------------------------------------------------
// utf8_strip_paced_text_fifo
// A result passes the store's registered read, then the output register.
// Throughput: one request per cycle unless the output stalls.
// Reset: pointers clear, the pace counter saturates and the interval returns
// to 2; the character store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module utf8_strip_paced_text_fifo #(
  parameter int unsigned QUEUE_DEPTH = usptf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  usptf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output usptf_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data
);
  import usptf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic             in_fire;
  logic             s1_adv;
  logic             s1_valid_r;
  res_info_t        s1_info_r;
  res_info_t        info;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [6:0]       mem_wdata, rdata_r;

  // The middle stage moves on whenever the output register is free or
  // being emptied, so new requests wait only while both stages are held.
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  usptf_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .info      (info)
  );

  usptf_char_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r <= info;
    end
    // The read data holds while the middle stage stalls, since no new
    // request and hence no new read can be taken then.
    if (s1_adv && s1_valid_r) begin
      out_item_r.char_valid  <= s1_info_r.char_valid;
      out_item_r.char_out    <= s1_info_r.char_valid ? rdata_r : 7'd0;
      out_item_r.queue_level <= s1_info_r.queue_level;
      out_item_r.dropped     <= s1_info_r.dropped;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the paced text queue against a cycle-free model of its filter, queue
// and pace counter. A short table of requests covers the filter's classes,
// then random host writes made of ASCII, control characters and whole and
// broken UTF-8 sequences are interleaved with ticks. The interval is moved
// through zero, one, the reset value, the maximum and a random setting.
// ----------------------------------------------------------------------------
module testbench;
  import usptf_pkg::*;

  localparam int unsigned STORE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_LEN = 80;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } text_vector_t;

  // Results are typed in only where they are plain; the rest go to the model.
  localparam text_vector_t DIRECTED [22] = '{
    '{'{KIND_TICK, 8'h00, 1'b0}, 1'b1, '{1'b0, 7'h00, 12'd0, 1'b0}},
    '{'{KIND_BYTE, 8'h41, 1'b0}, 1'b1, '{1'b0, 7'h00, 12'd1, 1'b0}},
    '{'{KIND_BYTE, CHAR_CR, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, CHAR_TAB, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, CHAR_LF, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, PRINTABLE_LOW, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, PRINTABLE_HIGH, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'h7F, 1'b0}, 1'b1, '{1'b0, 7'h00, 12'd5, 1'b0}},
    '{'{KIND_BYTE, 8'h00, 1'b0}, 1'b1, '{1'b0, 7'h00, 12'd5, 1'b0}},
    '{'{KIND_BYTE, 8'hC3, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'h41, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'hE2, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'h80, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'hFF, 1'b0}, 1'b1, '{1'b0, 7'h00, 12'd5, 1'b0}},
    '{'{KIND_BYTE, 8'hF0, 1'b1}, 1'b0, '0},
    '{'{KIND_BYTE, 8'h44, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'h80, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'hF8, 1'b0}, 1'b0, '0},
    '{'{KIND_BYTE, 8'hFF, 1'b1}, 1'b1, '{1'b0, 7'h00, 12'd6, 1'b0}},
    '{'{KIND_TICK, 8'hFF, 1'b1}, 1'b1, '{1'b1, 7'h41, 12'd5, 1'b0}},
    '{'{KIND_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{KIND_TICK, 8'h55, 1'b0}, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_we;
  logic [7:0] cfg_data;

  // Model of the queue, the filter state and the pace counter.
  logic [6:0]  mdl_chars [STORE_DEPTH];
  logic [11:0] mdl_rd;
  logic [11:0] mdl_wr;
  logic [1:0]  mdl_skip;
  logic        mdl_drop_mark;
  logic [7:0]  mdl_pace;
  logic [7:0]  mdl_interval;

  out_item_t   expected_results [$];
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_len      = 0;
  int unsigned quiet_cycles  = 0;

  utf8_strip_paced_text_fifo u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t predict_text_step(input in_item_t req);
    out_item_t   res;
    logic [11:0] nxt;
    logic [7:0]  c;
    res = '0;
    c   = req.data_byte;
    nxt = mdl_wr + 12'd1;
    if (req.kind == KIND_BYTE) begin
      if (mdl_skip != 2'd0) begin
        mdl_skip = mdl_skip - 2'd1;
      end else if (c[7]) begin
        // A stray continuation byte or anything from 0xF8 up goes on its own.
        if ((c & LEAD2_MASK) == LEAD2_CODE) begin
          mdl_skip = 2'd1;
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
          mdl_skip = 2'd2;
        end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
          mdl_skip = 2'd3;
        end
      end else if (c == CHAR_LF || c == CHAR_TAB ||
                   (c >= PRINTABLE_LOW && c <= PRINTABLE_HIGH)) begin
        if (mdl_drop_mark || nxt == mdl_rd) begin
          mdl_drop_mark = 1'b1;
          res.dropped   = 1'b1;
        end else begin
          mdl_chars[mdl_wr] = c[6:0];
          mdl_wr            = nxt;
        end
      end
      if (req.last_of_write) begin
        mdl_skip      = 2'd0;
        mdl_drop_mark = 1'b0;
      end
    end else begin
      if (mdl_pace != PACE_SATURATED) mdl_pace = mdl_pace + 8'd1;
      if (mdl_rd != mdl_wr && mdl_pace >= mdl_interval) begin
        res.char_valid = 1'b1;
        res.char_out   = mdl_chars[mdl_rd];
        mdl_rd         = mdl_rd + 12'd1;
        mdl_pace       = 8'd0;
      end
    end
    res.queue_level = mdl_wr - mdl_rd;
    return res;
  endfunction

  // Called in the time step of the previous acceptance, so that a request
  // following straight on keeps valid high without a second assignment.
  task automatic offer_request(input in_item_t req, input logic typed,
                               input out_item_t typed_res);
    out_item_t predicted;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_text_step(req);
    expected_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c, input logic last);
    in_item_t req;
    req.kind          = KIND_BYTE;
    req.data_byte     = c;
    req.last_of_write = last;
    offer_request(req, 1'b0, '0);
  endtask

  // Ticks carry random data and end marks, which the block must ignore.
  task automatic send_tick();
    in_item_t req;
    req.kind          = KIND_TICK;
    req.data_byte     = 8'($urandom);
    req.last_of_write = 1'($urandom);
    offer_request(req, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_interval(input logic [7:0] value);
    settle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    mdl_interval = value;
  endtask

  // One host write: mostly well-formed text, with stray and cut-short
  // UTF-8 sequences now and then, and ticks scattered between the bytes.
  task automatic send_random_write(input int unsigned tick_pct);
    logic [7:0]  text [$];
    int unsigned conts;
    repeat ($urandom_range(10, 1)) begin
      conts = 0;
      case ($urandom_range(9))
        0, 1, 2, 3: text.push_back(8'($urandom_range(126, 32)));
        4: begin
          case ($urandom_range(2))
            0:       text.push_back(CHAR_TAB);
            1:       text.push_back(CHAR_LF);
            default: text.push_back(CHAR_CR);
          endcase
        end
        5: begin
          text.push_back({3'b110, 5'($urandom)});
          conts = 1;
        end
        6: begin
          text.push_back({4'b1110, 4'($urandom)});
          conts = 2;
        end
        7: begin
          text.push_back({5'b11110, 3'($urandom)});
          conts = 3;
        end
        8: text.push_back(8'($urandom));
        default: begin
          // A four-byte lead short of its continuations eats bytes that follow it.
          text.push_back({5'b11110, 3'($urandom)});
          conts = $urandom_range(2);
        end
      endcase
      repeat (conts) text.push_back({2'b10, 6'($urandom)});
    end
    foreach (text[i]) begin
      while ($urandom_range(99) < tick_pct) send_tick();
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned tick_pct);
    int unsigned stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) send_random_write(tick_pct);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result %h arrived with no request outstanding", out_item);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.char_valid !== want.char_valid) begin
          $error("char_valid: expected %0d, got %0d", want.char_valid, out_item.char_valid);
          mismatches++;
        end
        if (out_item.char_out !== want.char_out) begin
          $error("char_out: expected %0h, got %0h", want.char_out, out_item.char_out);
          mismatches++;
        end
        if (out_item.queue_level !== want.queue_level) begin
          $error("queue_level: expected %0d, got %0d", want.queue_level,
                 out_item.queue_level);
          mismatches++;
        end
        if (out_item.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_item.dropped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : stimulus
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    mdl_rd        = '0;
    mdl_wr        = '0;
    mdl_skip      = '0;
    mdl_drop_mark = 1'b0;
    mdl_pace      = PACE_SATURATED;
    mdl_interval  = CHAR_INTERVAL_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 12;
    rcv_idle_pct = 78;
    foreach (DIRECTED[k]) offer_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].res);
    run_random(130, 35);

    // With a zero interval every tick drains a character while the queue holds one.
    snd_idle_pct = 78;
    rcv_idle_pct = 12;
    write_interval(8'd0);
    run_random(60, 45);
    settle();
    run_random(60, 45);

    // At the largest interval the few ticks here release nothing new, so
    // the queue only grows; a unit interval then drains it tick by tick.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_interval(8'hFF);
    run_random(40, 20);
    write_interval(8'd1);
    while (mdl_rd != mdl_wr) send_tick();

    write_interval(8'($urandom_range(6, 1)));
    hold_len = HOLD_OFF_LEN;
    run_random(130, 35);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/usptf_pkg.sv
src/usptf_char_ram.sv
src/usptf_ctrl.sv
src/utf8_strip_paced_text_fifo.sv
verif/testbench.sv
